[design/cmm_pkg.sv]
`default_nettype none
package cmm_pkg;

  localparam int NUM_CLASSES = 16;
  localparam int CLS_W       = $clog2(NUM_CLASSES);
  localparam int CNT_CLS_W   = CLS_W + 1;
  localparam int ADDR_W      = 2 * CLS_W;
  localparam int CELLS       = NUM_CLASSES * NUM_CLASSES;
  localparam int COUNT_W     = 32;
  localparam int FRAC_BITS   = 16;
  localparam int RATIO_W     = FRAC_BITS + 1;
  localparam int SUM_W       = COUNT_W + CLS_W + 2;
  localparam int DIVC_W      = $clog2(RATIO_W + 1);

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam logic [CNT_CLS_W-1:0] CLASS_COUNT_RESET = CNT_CLS_W'(NUM_CLASSES);

  typedef enum logic [1:0] {
    ACT_CLEAR  = 2'd0,
    ACT_RECORD = 2'd1,
    ACT_QUERY  = 2'd2,
    ACT_NOP    = 2'd3
  } act_t;

  typedef struct packed {
    logic [1:0]       action;
    logic [CLS_W-1:0] predicted_class;
    logic [CLS_W-1:0] actual_class;
    logic [CLS_W-1:0] query_class;
  } cmm_in_t;

  typedef struct packed {
    logic [COUNT_W-1:0] true_pos;
    logic [COUNT_W-1:0] false_pos;
    logic [COUNT_W-1:0] false_neg;
    logic [COUNT_W-1:0] true_neg;
    logic [RATIO_W-1:0] accuracy;
    logic [RATIO_W-1:0] precision;
    logic [RATIO_W-1:0] recall;
    logic [RATIO_W-1:0] fscore;
    logic [3:0]         valid_mask;
  } cmm_out_t;

  typedef struct packed {
    logic               en;
    logic [ADDR_W-1:0]  addr;
    logic [COUNT_W-1:0] data;
  } cmm_wr_t;

  typedef struct packed {
    logic             start;
    logic [SUM_W-1:0] num;
    logic [SUM_W-1:0] den;
  } cmm_div_req_t;

  function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
    return (v == COUNT_MAX) ? COUNT_MAX : v + COUNT_W'(1);
  endfunction

  function automatic logic [COUNT_W-1:0] sat_cnt(input logic [SUM_W-1:0] v);
    return (v > SUM_W'(COUNT_MAX)) ? COUNT_MAX : v[COUNT_W-1:0];
  endfunction

endpackage
`default_nettype wire

[design/cmm_store.sv]
`default_nettype none
module cmm_store (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        clear,
  input  wire cmm_pkg::cmm_wr_t            wr,
  input  wire logic [cmm_pkg::ADDR_W-1:0]  rd_addr_a,
  input  wire logic [cmm_pkg::ADDR_W-1:0]  rd_addr_b,
  output logic      [cmm_pkg::COUNT_W-1:0] rd_data_a,
  output logic      [cmm_pkg::COUNT_W-1:0] rd_data_b
);
  import cmm_pkg::*;

  logic [COUNT_W-1:0] mem [CELLS];
  logic [CELLS-1:0]   vld;
  logic [COUNT_W-1:0] q_a, q_b;
  logic               v_a, v_b;

  // entries not written since the last clear read as zero
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      vld <= '0;
    end else if (wr.en) begin
      vld[wr.addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    q_a <= mem[rd_addr_a];
    q_b <= mem[rd_addr_b];
    v_a <= vld[rd_addr_a];
    v_b <= vld[rd_addr_b];
  end

  assign rd_data_a = v_a ? q_a : '0;
  assign rd_data_b = v_b ? q_b : '0;
endmodule
`default_nettype wire

[design/cmm_divider.sv]
`default_nettype none
module cmm_divider (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire cmm_pkg::cmm_div_req_t       req,
  output logic                             done,
  output logic      [cmm_pkg::RATIO_W-1:0] quot
);
  import cmm_pkg::*;

  logic [SUM_W:0]      r;
  logic [SUM_W:0]      d;
  logic [SUM_W:0]      t;
  logic                ge;
  logic [DIVC_W-1:0]   cnt;
  logic                first;
  logic                run;

  // first step compares without shift to produce the integer bit
  assign t  = first ? r : {r[SUM_W-1:0], 1'b0};
  assign ge = (t >= d);

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        run <= 1'b1;
      end else if (run && cnt == DIVC_W'(1)) begin
        run  <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      r     <= {1'b0, req.num};
      d     <= {1'b0, req.den};
      quot  <= '0;
      cnt   <= DIVC_W'(RATIO_W);
      first <= 1'b1;
    end else if (run) begin
      r     <= ge ? t - d : t;
      quot  <= {quot[RATIO_W-2:0], ge};
      cnt   <= cnt - DIVC_W'(1);
      first <= 1'b0;
    end
  end
endmodule
`default_nettype wire

[design/confusion_matrix_metrics_core.sv]
`default_nettype none
// Confusion-matrix counter store with per-class metric queries.
// Clear: counters read as zero. Record: read, then saturating write-back.
// Query to the result word for n classes in use: a walk over n classes on
//   the two store read ports, the sum states CALC1 and CALC2, four serial
//   divisions (skipped for a zero denominator), then the output load.
// Sync active-high reset: class count 16, counters read as zero, no result.
module confusion_matrix_metrics_core (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire cmm_pkg::cmm_in_t                    in_data,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output cmm_pkg::cmm_out_t                        out_data,
  input  wire logic                                cfg_we,
  input  wire logic [cmm_pkg::CNT_CLS_W-1:0]       cfg_wdata
);
  import cmm_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_REC   = 7'b0000010,
    S_WALK  = 7'b0000100,
    S_CALC1 = 7'b0001000,
    S_CALC2 = 7'b0010000,
    S_DIV   = 7'b0100000,
    S_FIN   = 7'b1000000
  } state_t;

  state_t st;

  logic [CNT_CLS_W-1:0] class_count;
  logic [CNT_CLS_W-1:0] n_use;
  logic [COUNT_W-1:0]   total;
  logic                 accept;
  logic                 clear;
  logic                 rec_ok;
  logic                 q_ok;

  cmm_wr_t              wr;
  logic [ADDR_W-1:0]    rd_addr_a, rd_addr_b;
  logic [COUNT_W-1:0]   rd_a, rd_b;
  logic [ADDR_W-1:0]    rec_addr;

  logic [CLS_W-1:0]     qc;
  logic [CNT_CLS_W-1:0] cnt;
  logic                 acc_vld;
  logic [CLS_W-1:0]     acc_idx;
  logic [COUNT_W-1:0]   tp;
  logic [SUM_W-1:0]     rs, cs, fp_w, fn_w, sum3, tn;

  logic [1:0]           sel;
  logic                 waiting;
  logic [RATIO_W-1:0]   ratio [4];
  logic [3:0]           mask;
  logic [SUM_W-1:0]     num, den;
  cmm_div_req_t         dreq;
  logic                 ddone;
  logic [RATIO_W-1:0]   dquot;
  logic                 load_out;

  // classes in use: the register value capped at the built size
  assign n_use = (class_count > CNT_CLS_W'(NUM_CLASSES)) ?
                 CNT_CLS_W'(NUM_CLASSES) : class_count;

  assign in_stall = (st != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign clear    = accept && (act_t'(in_data.action) == ACT_CLEAR);
  assign rec_ok   = ({1'b0, in_data.predicted_class} < n_use) &&
                    ({1'b0, in_data.actual_class} < n_use);
  assign q_ok     = ({1'b0, in_data.query_class} < n_use);

  always_ff @(posedge clk) begin
    if (rst) begin
      class_count <= CLASS_COUNT_RESET;
    end else if (cfg_we) begin
      class_count <= cfg_wdata;
    end
  end

  // Port A: record target or row walk; port B: column walk.
  always_comb begin
    if (st == S_WALK) begin
      rd_addr_a = {qc, cnt[CLS_W-1:0]};
      rd_addr_b = {cnt[CLS_W-1:0], qc};
    end else begin
      rd_addr_a = {in_data.predicted_class, in_data.actual_class};
      rd_addr_b = {in_data.predicted_class, in_data.actual_class};
    end
  end

  // Write back the incremented cell in the cycle after the read.
  assign wr.en   = (st == S_REC);
  assign wr.addr = rec_addr;
  assign wr.data = sat_inc(rd_a);

  cmm_store u_store (
    .clk       (clk),
    .rst       (rst),
    .clear     (clear),
    .wr        (wr),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_a (rd_a),
    .rd_data_b (rd_b)
  );

  // Operands of the ratio selected by sel.
  always_comb begin
    unique case (sel)
      2'd0: begin
        num = SUM_W'(tp) + tn;
        den = sum3 + tn;
      end
      2'd1: begin
        num = SUM_W'(tp);
        den = rs;
      end
      2'd2: begin
        num = SUM_W'(tp);
        den = cs;
      end
      default: begin
        num = SUM_W'({tp, 1'b0});
        den = rs + cs;
      end
    endcase
  end

  assign dreq.start = (st == S_DIV) && !waiting && (den != '0);
  assign dreq.num   = num;
  assign dreq.den   = den;

  cmm_divider u_div (
    .clk  (clk),
    .rst  (rst),
    .req  (dreq),
    .done (ddone),
    .quot (dquot)
  );

  assign load_out = (st == S_FIN) && (!out_valid || !out_stall);

  // Control sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      st      <= S_IDLE;
      total   <= '0;
      acc_vld <= 1'b0;
      waiting <= 1'b0;
    end else begin
      unique case (st)
        S_IDLE: begin
          if (accept) begin
            unique case (act_t'(in_data.action))
              ACT_CLEAR: total <= '0;
              ACT_RECORD: begin
                if (rec_ok) begin
                  st <= S_REC;
                end
              end
              ACT_QUERY: st <= q_ok ? S_WALK : S_FIN;
              default: ;
            endcase
          end
        end
        S_REC: begin
          total <= sat_inc(total);
          st    <= S_IDLE;
        end
        S_WALK: begin
          acc_vld <= (cnt < n_use);
          if (cnt >= n_use && !acc_vld) begin
            st <= S_CALC1;
          end
        end
        S_CALC1: st <= S_CALC2;
        S_CALC2: st <= S_DIV;
        S_DIV: begin
          if (!waiting && den != '0) begin
            waiting <= 1'b1;
          end else if (!waiting || ddone) begin
            waiting <= 1'b0;
            if (sel == 2'd3) begin
              st <= S_FIN;
            end
          end
        end
        S_FIN: begin
          if (load_out) begin
            st <= S_IDLE;
          end
        end
        default: st <= S_IDLE;
      endcase
    end
  end

  // Datapath registers for the query walk and ratios.
  always_ff @(posedge clk) begin
    unique case (st)
      S_IDLE: begin
        rec_addr <= {in_data.predicted_class, in_data.actual_class};
        qc       <= in_data.query_class;
        cnt      <= '0;
        sel      <= '0;
        tp       <= '0;
        rs       <= '0;
        cs       <= '0;
        fp_w     <= '0;
        fn_w     <= '0;
        tn       <= '0;
        mask     <= '0;
        for (int k = 0; k < 4; k++) begin
          ratio[k] <= '0;
        end
      end
      S_WALK: begin
        if (cnt < n_use) begin
          cnt <= cnt + CNT_CLS_W'(1);
        end
        acc_idx <= cnt[CLS_W-1:0];
        if (acc_vld) begin
          rs <= rs + SUM_W'(rd_a);
          cs <= cs + SUM_W'(rd_b);
          if (acc_idx == qc) begin
            tp <= rd_a;
          end
        end
      end
      S_CALC1: begin
        fp_w <= rs - SUM_W'(tp);
        fn_w <= cs - SUM_W'(tp);
        sum3 <= rs + cs - SUM_W'(tp);
      end
      S_CALC2: begin
        tn <= (SUM_W'(total) > sum3) ? SUM_W'(total) - sum3 : '0;
      end
      S_DIV: begin
        // undefined ratio: hold zero, leave its mask bit clear
        if (!waiting && den == '0) begin
          sel <= sel + 2'd1;
        end else if (waiting && ddone) begin
          ratio[sel] <= dquot;
          mask[sel]  <= 1'b1;
          sel        <= sel + 2'd1;
        end
      end
      default: ;
    endcase
  end

  // Output word register; the input side keeps running while it waits.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data.true_pos   <= tp;
      out_data.false_pos  <= sat_cnt(fp_w);
      out_data.false_neg  <= sat_cnt(fn_w);
      out_data.true_neg   <= sat_cnt(tn);
      out_data.accuracy   <= ratio[0];
      out_data.precision  <= ratio[1];
      out_data.recall     <= ratio[2];
      out_data.fscore     <= ratio[3];
      out_data.valid_mask <= mask;
    end
  end

  // A record write-back always follows an accepted in-range record.
  a_rec_follows: assert property (@(posedge clk) disable iff (rst)
    (st == S_REC) |-> $past(accept))
    else $error("record write-back without accepted record");

  // The divider finishes only while the sequencer waits for it.
  a_div_done: assert property (@(posedge clk) disable iff (rst)
    ddone |-> (st == S_DIV && waiting))
    else $error("divider done outside of division phase");

  // A new result word comes only from the final state.
  a_out_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(st == S_FIN))
    else $error("result word raised outside final state");

  // Precision in the result word never exceeds one.
  a_ratio_max: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.precision <= RATIO_W'(1 << FRAC_BITS)))
    else $error("precision above one");
endmodule
`default_nettype wire
